### rtl/rect_collision_edge_select_assert.svh
// assertion macros shared by the rect collision edge select rtl
`ifndef RECT_COLLISION_EDGE_SELECT_ASSERT_SVH
`define RECT_COLLISION_EDGE_SELECT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define RCES_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rect collision edge select: same-cycle check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define RCES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rect collision edge select: next-cycle check failed");

`endif

### rtl/rces_pkg.sv
// shared constants for the rect collision edge select block
`default_nettype none

package rces_pkg;

   // default coordinate width, signed q12.4
   localparam int COORD_WIDTH_DEF = 16;

   // side codes, also used as index into the a-edge arrays
   localparam logic [1:0] SIDE_LEFT   = 2'd0;
   localparam logic [1:0] SIDE_TOP    = 2'd1;
   localparam logic [1:0] SIDE_RIGHT  = 2'd2;
   localparam logic [1:0] SIDE_BOTTOM = 2'd3;

   // number of corners per rectangle
   localparam int NUM_CORNERS = 4;

endpackage

`default_nettype wire

### rtl/rces_ifs.sv
// request and response channel interfaces for the rect collision edge select block
`default_nettype none

// request channel: two rectangles per beat
interface rces_req_if #(
   parameter int COORD_WIDTH = rces_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] a_left;
   logic signed [COORD_WIDTH-1:0] a_top;
   logic signed [COORD_WIDTH-1:0] a_right;
   logic signed [COORD_WIDTH-1:0] a_bottom;
   logic signed [COORD_WIDTH-1:0] b_left;
   logic signed [COORD_WIDTH-1:0] b_top;
   logic signed [COORD_WIDTH-1:0] b_right;
   logic signed [COORD_WIDTH-1:0] b_bottom;

   modport source (
      output valid, a_left, a_top, a_right, a_bottom,
             b_left, b_top, b_right, b_bottom,
      input  ready
   );
   modport sink (
      input  valid, a_left, a_top, a_right, a_bottom,
             b_left, b_top, b_right, b_bottom,
      output ready
   );
endinterface

// response channel: hit flag, struck side and edge endpoints per beat
interface rces_rsp_if #(
   parameter int COORD_WIDTH = rces_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [1:0]                    side_code;
   logic signed [COORD_WIDTH-1:0] edge_x0;
   logic signed [COORD_WIDTH-1:0] edge_y0;
   logic signed [COORD_WIDTH-1:0] edge_x1;
   logic signed [COORD_WIDTH-1:0] edge_y1;

   modport source (
      output valid, hit, side_code, edge_x0, edge_y0, edge_x1, edge_y1,
      input  ready
   );
   modport sink (
      input  valid, hit, side_code, edge_x0, edge_y0, edge_x1, edge_y1,
      output ready
   );
endinterface

`default_nettype wire

### rtl/rect_collision_edge_select.sv
// Rect collision edge select: finds whether two axis-aligned rectangles A and B
// overlap at a corner and which edge of A was struck.
//
// req_chan carries one rectangle pair per beat (edges left, top, right, bottom,
// signed fixed point, y growing downward). rsp_chan returns one beat per request:
// hit, the struck side of A (left, top, right, bottom) and that edge's two
// endpoints; with no hit all fields other than hit are zero.
// Pipeline: six register stages, the last one the output register. A request
// passes through the stages in order, and its response is driven from the output
// register. Throughput: one beat per clock while rsp_chan is not stalled; the
// squared-distance multipliers sit in stage 3, beside the edge-line distances.
// Each stage has its own valid bit and moves on when the next stage is empty or
// moves too, so bubbles close up and req_chan.ready stays high while rsp_chan is
// stalled until all six stages are full. A stall loses and repeats nothing.
// Synchronous reset clears all valid bits; no response is pending after reset.
`default_nettype none

`include "rect_collision_edge_select_assert.svh"

module rect_collision_edge_select #(
   parameter int COORD_WIDTH = rces_pkg::COORD_WIDTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   rces_req_if.sink        req_chan,
   rces_rsp_if.source      rsp_chan
);
   import rces_pkg::*;

   localparam int W      = COORD_WIDTH;
   localparam int SW     = W + 2;         // sums and midpoint differences
   localparam int DW     = W + 4;         // count-scaled edge distances
   localparam int QW     = 2 * W + 4;     // squared distance per axis
   localparam int MW     = 2 * W + 5;     // compare metric
   localparam int NSTAGE = 6;

   // per-stage valid bits and advance chain
   logic [NSTAGE:1]   v_ff;
   logic [NSTAGE+1:1] adv;

   // stage 1: corner tests and pre-sums
   logic signed [W-1:0] s1_a_ff [NUM_CORNERS];
   logic signed [W-1:0] s1_b_ff [NUM_CORNERS];
   logic [NUM_CORNERS-1:0] s1_bin_ff, s1_bin_in;
   logic                s1_ain_ff, s1_ain_in;
   logic signed [W:0]   s1_cx_ff, s1_cy_ff, s1_sa_ff, s1_st_ff;

   // stage 2: inside-corner sums and midpoint offsets
   logic signed [W-1:0] s2_a_ff [NUM_CORNERS];
   logic                s2_hit_ff;
   logic [2:0]          s2_n_ff, s2_n_in;
   logic signed [SW-1:0] s2_sx_ff, s2_sy_ff, s2_sx_in, s2_sy_in;
   logic [SW-1:0]       s2_mdx_ff [NUM_CORNERS];
   logic [SW-1:0]       s2_mdy_ff [NUM_CORNERS];
   logic [SW-1:0]       s2_mdx_in [NUM_CORNERS];
   logic [SW-1:0]       s2_mdy_in [NUM_CORNERS];

   // stage 3: edge-line distances and squares
   logic signed [W-1:0] s3_a_ff [NUM_CORNERS];
   logic                s3_hit_ff, s3_nz_ff;
   logic [DW-1:0]       s3_d_ff [NUM_CORNERS];
   logic [DW-1:0]       s3_d_in [NUM_CORNERS];
   logic [QW-1:0]       s3_sqx_ff [NUM_CORNERS];
   logic [QW-1:0]       s3_sqy_ff [NUM_CORNERS];

   // stage 4: one metric per edge
   logic signed [W-1:0] s4_a_ff [NUM_CORNERS];
   logic                s4_hit_ff;
   logic [MW-1:0]       s4_m_ff [NUM_CORNERS];

   // stage 5: pair winners
   logic signed [W-1:0] s5_a_ff [NUM_CORNERS];
   logic                s5_hit_ff;
   logic [MW-1:0]       s5_m01_ff, s5_m23_ff;
   logic                s5_i01_ff, s5_i23_ff;

   // stage 6: output register
   logic                o_hit_ff, o_hit_in;
   logic [1:0]          o_side_ff, o_side_in;
   logic signed [W-1:0] o_x0_ff, o_y0_ff, o_x1_ff, o_y1_ff;
   logic signed [W-1:0] o_x0_in, o_y0_in, o_x1_in, o_y1_in;

   // advance chain from the output back to the input
   always_comb begin
      adv[NSTAGE+1] = rsp_chan.ready;
      for (int k = NSTAGE; k >= 1; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign req_chan.ready = adv[1];

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[1]) begin
            v_ff[1] <= req_chan.valid;
         end
         for (int k = 2; k <= NSTAGE; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // stage 1 logic: strict inside tests for all eight corners
   always_comb begin
      logic signed [W-1:0] bx [NUM_CORNERS];
      logic signed [W-1:0] by [NUM_CORNERS];
      logic signed [W-1:0] ax [NUM_CORNERS];
      logic signed [W-1:0] ay [NUM_CORNERS];
      bx[0] = req_chan.b_left;  by[0] = req_chan.b_top;
      bx[1] = req_chan.b_right; by[1] = req_chan.b_top;
      bx[2] = req_chan.b_right; by[2] = req_chan.b_bottom;
      bx[3] = req_chan.b_left;  by[3] = req_chan.b_bottom;
      ax[0] = req_chan.a_left;  ay[0] = req_chan.a_top;
      ax[1] = req_chan.a_right; ay[1] = req_chan.a_top;
      ax[2] = req_chan.a_right; ay[2] = req_chan.a_bottom;
      ax[3] = req_chan.a_left;  ay[3] = req_chan.a_bottom;
      s1_ain_in = 1'b0;
      for (int k = 0; k < NUM_CORNERS; k++) begin
         s1_bin_in[k] = (bx[k] > req_chan.a_left) && (by[k] > req_chan.a_top) &&
                        (bx[k] < req_chan.a_right) && (by[k] < req_chan.a_bottom);
         if ((ax[k] > req_chan.b_left) && (ay[k] > req_chan.b_top) &&
             (ax[k] < req_chan.b_right) && (ay[k] < req_chan.b_bottom)) begin
            s1_ain_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_a_ff[SIDE_LEFT]   <= req_chan.a_left;
         s1_a_ff[SIDE_TOP]    <= req_chan.a_top;
         s1_a_ff[SIDE_RIGHT]  <= req_chan.a_right;
         s1_a_ff[SIDE_BOTTOM] <= req_chan.a_bottom;
         s1_b_ff[SIDE_LEFT]   <= req_chan.b_left;
         s1_b_ff[SIDE_TOP]    <= req_chan.b_top;
         s1_b_ff[SIDE_RIGHT]  <= req_chan.b_right;
         s1_b_ff[SIDE_BOTTOM] <= req_chan.b_bottom;
         s1_bin_ff <= s1_bin_in;
         s1_ain_ff <= s1_ain_in;
         s1_cx_ff  <= (W+1)'(req_chan.b_left) + (W+1)'(req_chan.b_right);
         s1_cy_ff  <= (W+1)'(req_chan.b_top) + (W+1)'(req_chan.b_bottom);
         s1_sa_ff  <= (W+1)'(req_chan.a_left) + (W+1)'(req_chan.a_right);
         s1_st_ff  <= (W+1)'(req_chan.a_top) + (W+1)'(req_chan.a_bottom);
      end
   end

   // stage 2 logic: corner count and sums, doubled center minus doubled midpoints
   always_comb begin
      logic signed [W-1:0]  bx [NUM_CORNERS];
      logic signed [W-1:0]  by [NUM_CORNERS];
      logic signed [SW-1:0] mx [NUM_CORNERS];
      logic signed [SW-1:0] my [NUM_CORNERS];
      logic signed [SW-1:0] dx, dy;
      bx[0] = s1_b_ff[SIDE_LEFT];  by[0] = s1_b_ff[SIDE_TOP];
      bx[1] = s1_b_ff[SIDE_RIGHT]; by[1] = s1_b_ff[SIDE_TOP];
      bx[2] = s1_b_ff[SIDE_RIGHT]; by[2] = s1_b_ff[SIDE_BOTTOM];
      bx[3] = s1_b_ff[SIDE_LEFT];  by[3] = s1_b_ff[SIDE_BOTTOM];
      s2_n_in  = '0;
      s2_sx_in = '0;
      s2_sy_in = '0;
      for (int k = 0; k < NUM_CORNERS; k++) begin
         if (s1_bin_ff[k]) begin
            s2_n_in  = s2_n_in + 3'd1;
            s2_sx_in = s2_sx_in + SW'(bx[k]);
            s2_sy_in = s2_sy_in + SW'(by[k]);
         end
      end
      mx[SIDE_LEFT]   = SW'(s1_a_ff[SIDE_LEFT]) + SW'(s1_a_ff[SIDE_LEFT]);
      my[SIDE_LEFT]   = SW'(s1_st_ff);
      mx[SIDE_TOP]    = SW'(s1_sa_ff);
      my[SIDE_TOP]    = SW'(s1_a_ff[SIDE_TOP]) + SW'(s1_a_ff[SIDE_TOP]);
      mx[SIDE_RIGHT]  = SW'(s1_a_ff[SIDE_RIGHT]) + SW'(s1_a_ff[SIDE_RIGHT]);
      my[SIDE_RIGHT]  = SW'(s1_st_ff);
      mx[SIDE_BOTTOM] = SW'(s1_sa_ff);
      my[SIDE_BOTTOM] = SW'(s1_a_ff[SIDE_BOTTOM]) + SW'(s1_a_ff[SIDE_BOTTOM]);
      for (int k = 0; k < NUM_CORNERS; k++) begin
         dx = SW'(s1_cx_ff) - mx[k];
         dy = SW'(s1_cy_ff) - my[k];
         s2_mdx_in[k] = dx[SW-1] ? SW'(-dx) : SW'(dx);
         s2_mdy_in[k] = dy[SW-1] ? SW'(-dy) : SW'(dy);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_a_ff   <= s1_a_ff;
         s2_hit_ff <= (|s1_bin_ff) || s1_ain_ff;
         s2_n_ff   <= s2_n_in;
         s2_sx_ff  <= s2_sx_in;
         s2_sy_ff  <= s2_sy_in;
         s2_mdx_ff <= s2_mdx_in;
         s2_mdy_ff <= s2_mdy_in;
      end
   end

   // stage 3 logic: n times each edge against the coordinate sums
   always_comb begin
      logic signed [3:0]    nn;
      logic signed [DW-1:0] t [NUM_CORNERS];
      nn = $signed({1'b0, s2_n_ff});
      t[SIDE_LEFT]   = DW'(nn) * DW'(s2_a_ff[SIDE_LEFT]) - DW'(s2_sx_ff);
      t[SIDE_TOP]    = DW'(s2_sy_ff) - DW'(nn) * DW'(s2_a_ff[SIDE_TOP]);
      t[SIDE_RIGHT]  = DW'(nn) * DW'(s2_a_ff[SIDE_RIGHT]) - DW'(s2_sx_ff);
      t[SIDE_BOTTOM] = DW'(nn) * DW'(s2_a_ff[SIDE_BOTTOM]) - DW'(s2_sy_ff);
      for (int k = 0; k < NUM_CORNERS; k++) begin
         s3_d_in[k] = t[k][DW-1] ? DW'(-t[k]) : DW'(t[k]);
      end
   end

   // squares of the midpoint offsets, one multiplier per term
   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_a_ff   <= s2_a_ff;
         s3_hit_ff <= s2_hit_ff;
         s3_nz_ff  <= (s2_n_ff != 3'd0);
         s3_d_ff   <= s3_d_in;
         for (int k = 0; k < NUM_CORNERS; k++) begin
            s3_sqx_ff[k] <= QW'(s2_mdx_ff[k]) * QW'(s2_mdx_ff[k]);
            s3_sqy_ff[k] <= QW'(s2_mdy_ff[k]) * QW'(s2_mdy_ff[k]);
         end
      end
   end

   // stage 4: pick the metric that applies to this beat
   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_a_ff   <= s3_a_ff;
         s4_hit_ff <= s3_hit_ff;
         for (int k = 0; k < NUM_CORNERS; k++) begin
            s4_m_ff[k] <= s3_nz_ff ? MW'(s3_d_ff[k])
                                   : MW'(s3_sqx_ff[k]) + MW'(s3_sqy_ff[k]);
         end
      end
   end

   // stage 5: first compare level, the lower edge keeps ties
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_a_ff   <= s4_a_ff;
         s5_hit_ff <= s4_hit_ff;
         s5_i01_ff <= (s4_m_ff[1] < s4_m_ff[0]);
         s5_m01_ff <= (s4_m_ff[1] < s4_m_ff[0]) ? s4_m_ff[1] : s4_m_ff[0];
         s5_i23_ff <= (s4_m_ff[3] < s4_m_ff[2]);
         s5_m23_ff <= (s4_m_ff[3] < s4_m_ff[2]) ? s4_m_ff[3] : s4_m_ff[2];
      end
   end

   // stage 6 logic: final compare and edge endpoints
   always_comb begin
      logic [1:0] side;
      side = (s5_m23_ff < s5_m01_ff) ? {1'b1, s5_i23_ff} : {1'b0, s5_i01_ff};
      o_hit_in = s5_hit_ff;
      unique case (side)
         SIDE_LEFT: begin
            o_x0_in = s5_a_ff[SIDE_LEFT];  o_y0_in = s5_a_ff[SIDE_TOP];
            o_x1_in = s5_a_ff[SIDE_LEFT];  o_y1_in = s5_a_ff[SIDE_BOTTOM];
         end
         SIDE_TOP: begin
            o_x0_in = s5_a_ff[SIDE_LEFT];  o_y0_in = s5_a_ff[SIDE_TOP];
            o_x1_in = s5_a_ff[SIDE_RIGHT]; o_y1_in = s5_a_ff[SIDE_TOP];
         end
         SIDE_RIGHT: begin
            o_x0_in = s5_a_ff[SIDE_RIGHT]; o_y0_in = s5_a_ff[SIDE_TOP];
            o_x1_in = s5_a_ff[SIDE_RIGHT]; o_y1_in = s5_a_ff[SIDE_BOTTOM];
         end
         SIDE_BOTTOM: begin
            o_x0_in = s5_a_ff[SIDE_LEFT];  o_y0_in = s5_a_ff[SIDE_BOTTOM];
            o_x1_in = s5_a_ff[SIDE_RIGHT]; o_y1_in = s5_a_ff[SIDE_BOTTOM];
         end
         default: begin
            o_x0_in = '0; o_y0_in = '0; o_x1_in = '0; o_y1_in = '0;
         end
      endcase
      o_side_in = side;
      // no hit clears everything
      if (!s5_hit_ff) begin
         o_side_in = SIDE_LEFT;
         o_x0_in   = '0;
         o_y0_in   = '0;
         o_x1_in   = '0;
         o_y1_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         o_hit_ff  <= o_hit_in;
         o_side_ff <= o_side_in;
         o_x0_ff   <= o_x0_in;
         o_y0_ff   <= o_y0_in;
         o_x1_ff   <= o_x1_in;
         o_y1_ff   <= o_y1_in;
      end
   end

   // response beat
   assign rsp_chan.valid     = v_ff[NSTAGE];
   assign rsp_chan.hit       = o_hit_ff;
   assign rsp_chan.side_code = o_side_ff;
   assign rsp_chan.edge_x0   = o_x0_ff;
   assign rsp_chan.edge_y0   = o_y0_ff;
   assign rsp_chan.edge_x1   = o_x1_ff;
   assign rsp_chan.edge_y1   = o_y1_ff;

   // checks
   logic chk_axis_ok;
   logic chk_nohit_zero;
   logic req_beat;
   logic rsp_stall;

   assign req_beat  = req_chan.valid && req_chan.ready;
   assign rsp_stall = rsp_chan.valid && !rsp_chan.ready;
   assign chk_axis_ok = (o_side_ff == SIDE_LEFT || o_side_ff == SIDE_RIGHT) ?
                        (o_x0_ff == o_x1_ff) : (o_y0_ff == o_y1_ff);
   assign chk_nohit_zero = o_hit_ff || ((o_side_ff == SIDE_LEFT) && (o_x0_ff == '0) &&
                           (o_y0_ff == '0) && (o_x1_ff == '0) && (o_y1_ff == '0));

   `RCES_ASSERT_NEXT(a_req_enters_stage1, clock, reset, req_beat, v_ff[1])
   `RCES_ASSERT_NEXT(a_rsp_held_on_stall, clock, reset, rsp_stall, v_ff[NSTAGE])
   `RCES_ASSERT_SAME(a_edge_on_one_axis, clock, reset, rsp_chan.valid, chk_axis_ok)
   `RCES_ASSERT_SAME(a_nohit_all_zero, clock, reset, rsp_chan.valid, chk_nohit_zero)

endmodule

`default_nettype wire
